### design/plc_pkg.sv
// shared types and constants for the piecewise linear curve evaluator
// used by piecewise_linear_curve_eval and plc_div; no dependencies
package plc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_EVAL  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic               status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_SH_RD,
    S_SH_WR,
    S_ADD_WR,
    S_EV_RD,
    S_EV_CHK,
    S_EV_SEG,
    S_EV_LAST,
    S_EV_P0,
    S_EV_P1,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RESP
  } state_t;

endpackage

### design/plc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on plc_pkg for operand widths
module plc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [plc_pkg::DIVIDEND_W-1:0]       dividend,
  input  logic [plc_pkg::DIVISOR_W-1:0]        divisor,
  output logic                                 done,
  output logic [plc_pkg::DIVIDEND_W-1:0]       quotient
);

  localparam int CNT_DW = $clog2(plc_pkg::DIVIDEND_W + 1);

  logic [plc_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [plc_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [plc_pkg::DIVISOR_W-1:0]  dvs_r;
  logic [CNT_DW-1:0]              cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [plc_pkg::DIVISOR_W:0]    rem_sh;
  logic [plc_pkg::DIVISOR_W:0]    rem_sub;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_sh   = {rem_r, quo_r[plc_pkg::DIVIDEND_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_DW'(plc_pkg::DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[plc_pkg::DIVISOR_W-1:0];
        quo_nxt = {quo_r[plc_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[plc_pkg::DIVISOR_W-1:0];
        quo_nxt = {quo_r[plc_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_DW'(1);
      if (cnt_r == CNT_DW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### design/piecewise_linear_curve_eval.sv
// top level of the piecewise linear curve evaluator: point table memories,
// sequencer and interpolation datapath; depends on plc_pkg and plc_div
//
// usage
//   in_data carries kind, coord_x, coord_y; one out_data transaction
//   answers every in_data transaction, in order
//   clear: zeroes the point count, then hands its result to the output register
//   add: compares the stored points in order to find the slot, moves
//     the points above it up by one and writes the new point; a full
//     table answers status 1
//   evaluate: scans points from the cached segment, then, for an interior
//     segment, waits on the 64-step serial divider; an empty table, the
//     last point or a zero-width segment answer without the divider
//   one transaction is worked on at a time, all table access through the
//   single read port of the point memories, read data registered
//   reset empties the table and zeroes the cached segment and last query;
//   the memories are not cleared
//   a stalled receiver holds the result in the output register; one more
//   input transaction is taken and worked up to its result meanwhile
module piecewise_linear_curve_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plc_pkg::out_item_t  out_data
);

  localparam int IW = plc_pkg::IDX_W;
  localparam int CW = plc_pkg::CNT_W;

  // point table
  logic signed [31:0] xs_mem [plc_pkg::MAX_POINTS];
  logic signed [31:0] ys_mem [plc_pkg::MAX_POINTS];
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [IW-1:0]      mem_raddr;
  logic signed [31:0] mem_wx;
  logic signed [31:0] mem_wy;
  logic signed [31:0] rd_x_r;
  logic signed [31:0] rd_y_r;

  plc_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      cache_r, cache_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      shi_r, shi_nxt;
  logic [CW-1:0]      seg_r, seg_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic signed [31:0] x0_r, x0_nxt;
  logic signed [31:0] y0_r, y0_nxt;
  logic [31:0]        mdx_r, mdx_nxt;
  logic [31:0]        mdy_r, mdy_nxt;
  logic [31:0]        mdq_r, mdq_nxt;
  logic               neg_r, neg_nxt;
  logic               dxz_r, dxz_nxt;
  logic [63:0]        prod_r;
  logic signed [31:0] res_r, res_nxt;
  logic               sts_r, sts_nxt;
  logic               out_valid_r, out_valid_nxt;
  plc_pkg::out_item_t out_r, out_nxt;

  logic               div_start;
  logic               div_done;
  logic [63:0]        div_quo;

  logic [CW-1:0]      seg_w;
  logic signed [32:0] dx_w, dy_w, dq_w;
  logic signed [32:0] adx_w, ady_w, adq_w;
  logic [33:0]        qc_w;
  logic signed [34:0] sq_w, sum_w;

  // serial divider for the interpolation quotient
  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (mdx_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == plc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // segment differences and their magnitudes
  always_comb begin
    dx_w  = 33'(rd_x_r) - 33'(x0_r);
    dy_w  = 33'(rd_y_r) - 33'(y0_r);
    dq_w  = 33'(x_r) - 33'(x0_r);
    adx_w = dx_w[32] ? -dx_w : dx_w;
    ady_w = dy_w[32] ? -dy_w : dy_w;
    adq_w = dq_w[32] ? -dq_w : dq_w;
  end

  // clamp, sign and offset of the quotient; the sequencer saturates the sum
  always_comb begin
    qc_w  = (div_quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_quo[33:0];
    sq_w  = neg_r ? -$signed({1'b0, qc_w}) : $signed({1'b0, qc_w});
    sum_w = sq_w + 35'(y0_r);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cache_nxt     = cache_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    shi_nxt       = shi_r;
    seg_nxt       = seg_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    mdx_nxt       = mdx_r;
    mdy_nxt       = mdy_r;
    mdq_nxt       = mdq_r;
    neg_nxt       = neg_r;
    dxz_nxt       = dxz_r;
    res_nxt       = res_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r[IW-1:0];
    mem_wx        = x_r;
    mem_wy        = y_r;
    mem_raddr     = pos_r[IW-1:0];
    div_start     = 1'b0;
    seg_w         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      plc_pkg::S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_data.coord_x;
          y_nxt     = in_data.coord_y;
          res_nxt   = '0;
          sts_nxt   = 1'b0;
          pos_nxt   = '0;
          shi_nxt   = cnt_r;
          state_nxt = plc_pkg::S_RESP;
          case (in_data.kind)
            plc_pkg::KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            plc_pkg::KIND_ADD: begin
              if (cnt_r >= CW'(plc_pkg::MAX_POINTS)) begin
                sts_nxt = 1'b1;
              end else begin
                state_nxt = plc_pkg::S_ADD_RD;
              end
            end
            plc_pkg::KIND_EVAL: begin
              if (cnt_r != '0) begin
                prev_nxt = in_data.coord_x;
                if (prev_r >= in_data.coord_x) begin
                  pos_nxt = '0;
                end else begin
                  pos_nxt = (cache_r < cnt_r) ? cache_r : cnt_r;
                end
                state_nxt = plc_pkg::S_EV_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // find the slot after all points with x at or below the new x
      plc_pkg::S_ADD_RD: begin
        if (pos_r < cnt_r) begin
          mem_raddr = pos_r[IW-1:0];
          state_nxt = plc_pkg::S_ADD_CHK;
        end else begin
          state_nxt = plc_pkg::S_SH_RD;
        end
      end
      plc_pkg::S_ADD_CHK: begin
        if (rd_x_r <= x_r) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = plc_pkg::S_ADD_RD;
        end else begin
          state_nxt = plc_pkg::S_SH_RD;
        end
      end
      // move the points above the slot up by one, top first
      plc_pkg::S_SH_RD: begin
        if (shi_r > pos_r) begin
          mem_raddr = IW'(shi_r - CW'(1));
          state_nxt = plc_pkg::S_SH_WR;
        end else begin
          state_nxt = plc_pkg::S_ADD_WR;
        end
      end
      plc_pkg::S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = shi_r[IW-1:0];
        mem_wx    = rd_x_r;
        mem_wy    = rd_y_r;
        shi_nxt   = shi_r - CW'(1);
        state_nxt = plc_pkg::S_SH_RD;
      end
      plc_pkg::S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = plc_pkg::S_RESP;
      end
      // scan forward for the first point right of the query
      plc_pkg::S_EV_RD: begin
        if (pos_r < cnt_r) begin
          mem_raddr = pos_r[IW-1:0];
          state_nxt = plc_pkg::S_EV_CHK;
        end else begin
          state_nxt = plc_pkg::S_EV_SEG;
        end
      end
      plc_pkg::S_EV_CHK: begin
        if (x_r < rd_x_r) begin
          state_nxt = plc_pkg::S_EV_SEG;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = plc_pkg::S_EV_RD;
        end
      end
      plc_pkg::S_EV_SEG: begin
        if (pos_r < cnt_r) begin
          seg_w = (pos_r == '0) ? '0 : pos_r - CW'(1);
        end else begin
          seg_w = cnt_r - CW'(1);
        end
        seg_nxt = seg_w;
        if (seg_w + CW'(1) >= cnt_r) begin
          cache_nxt = cnt_r;
          mem_raddr = IW'(cnt_r - CW'(1));
          state_nxt = plc_pkg::S_EV_LAST;
        end else begin
          cache_nxt = seg_w + CW'(1);
          mem_raddr = seg_w[IW-1:0];
          state_nxt = plc_pkg::S_EV_P0;
        end
      end
      plc_pkg::S_EV_LAST: begin
        res_nxt   = rd_y_r;
        state_nxt = plc_pkg::S_RESP;
      end
      plc_pkg::S_EV_P0: begin
        x0_nxt    = rd_x_r;
        y0_nxt    = rd_y_r;
        mem_raddr = IW'(seg_r + CW'(1));
        state_nxt = plc_pkg::S_EV_P1;
      end
      plc_pkg::S_EV_P1: begin
        mdx_nxt   = adx_w[31:0];
        mdy_nxt   = ady_w[31:0];
        mdq_nxt   = adq_w[31:0];
        neg_nxt   = ((dy_w[32] != dq_w[32]) != dx_w[32]);
        dxz_nxt   = (dx_w == '0);
        state_nxt = plc_pkg::S_MUL;
      end
      plc_pkg::S_MUL: begin
        if (dxz_r) begin
          res_nxt   = y0_r;
          state_nxt = plc_pkg::S_RESP;
        end else begin
          state_nxt = plc_pkg::S_DIV_GO;
        end
      end
      plc_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = plc_pkg::S_DIV_WAIT;
      end
      plc_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (sum_w > 35'sd2147483647) begin
            res_nxt = 32'sh7fff_ffff;
          end else if (sum_w < -35'sd2147483648) begin
            res_nxt = 32'sh8000_0000;
          end else begin
            res_nxt = sum_w[31:0];
          end
          state_nxt = plc_pkg::S_RESP;
        end
      end
      // hand the result to the output register once it is free
      plc_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.curve_value = res_r;
          out_nxt.status      = sts_r;
          state_nxt           = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

  // point memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      xs_mem[mem_waddr] <= mem_wx;
      ys_mem[mem_waddr] <= mem_wy;
    end
    rd_x_r <= xs_mem[mem_raddr];
    rd_y_r <= ys_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plc_pkg::S_IDLE;
      cnt_r       <= '0;
      cache_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cache_r     <= cache_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    shi_r  <= shi_nxt;
    seg_r  <= seg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    mdx_r  <= mdx_nxt;
    mdy_r  <= mdy_nxt;
    mdq_r  <= mdq_nxt;
    neg_r  <= neg_nxt;
    dxz_r  <= dxz_nxt;
    prod_r <= mdy_r * mdq_r;
    res_r  <= res_nxt;
    sts_r  <= sts_nxt;
    out_r  <= out_nxt;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(plc_pkg::MAX_POINTS))
    else $error("point count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != plc_pkg::S_IDLE))
    else $error("accepted transaction left no work");

  a_full_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |-> (out_r.curve_value == '0))
    else $error("dropped point with non-zero value");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == plc_pkg::S_DIV_WAIT))
    else $error("divider finished outside its wait state");

endmodule

### bench/tb.sv
// self-checking bench for piecewise_linear_curve_eval: curve predictor,
// directed and random tests, result checker; depends on plc_pkg and the block
module tb;

  localparam int LIMIT_CYCLES = 1500000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  plc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  plc_pkg::out_item_t out_data;

  // predictor state
  logic signed [31:0] tbl_x [plc_pkg::MAX_POINTS];
  logic signed [31:0] tbl_y [plc_pkg::MAX_POINTS];
  int unsigned tbl_count;
  int unsigned seg_cache;
  logic signed [31:0] last_query;

  plc_pkg::out_item_t pending_results[$];
  int error_count;
  int cycle_count;
  int sent_count;
  int checked_count;
  int full_drops;
  bit draining;

  piecewise_linear_curve_eval DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("cycle limit reached");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] x0,
      logic signed [31:0] y0, logic signed [31:0] x1, logic signed [31:0] y1,
      logic signed [31:0] x);
    logic signed [63:0] dx, dy, dq, r;
    logic [63:0] q, mdx, mdy, mdq;
    logic neg;
    dx = 64'(x1) - 64'(x0);
    dy = 64'(y1) - 64'(y0);
    dq = 64'(x) - 64'(x0);
    if (dx == 0) return y0;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    // magnitudes as unsigned so the product cannot wrap
    mdx = dx < 0 ? -dx : dx;
    mdy = dy < 0 ? -dy : dy;
    mdq = dq < 0 ? -dq : dq;
    q = (mdy * mdq) / mdx;
    if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
    r = neg ? -$signed(q) : $signed(q);
    r = r + 64'(y0);
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] curve_at(logic signed [31:0] x);
    int unsigned idx, seg;
    if (tbl_count == 0) return 0;
    if (last_query >= x) seg_cache = 0;
    last_query = x;
    idx = seg_cache < tbl_count ? seg_cache : tbl_count;
    while (idx < tbl_count && !(x < tbl_x[idx])) idx++;
    if (idx < tbl_count) seg = idx == 0 ? 0 : idx - 1;
    else seg = tbl_count - 1;
    if (seg + 1 >= tbl_count) begin
      seg_cache = tbl_count;
      return tbl_y[tbl_count - 1];
    end
    seg_cache = seg + 1;
    return lerp_q16(tbl_x[seg], tbl_y[seg], tbl_x[seg + 1], tbl_y[seg + 1], x);
  endfunction

  function automatic plc_pkg::out_item_t predict_curve(plc_pkg::in_item_t it);
    plc_pkg::out_item_t res;
    int unsigned pos;
    res = '0;
    case (it.kind)
      plc_pkg::KIND_CLEAR: tbl_count = 0;
      plc_pkg::KIND_ADD: begin
        if (tbl_count >= plc_pkg::MAX_POINTS) begin
          res.status = 1'b1;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_x[pos] <= it.coord_x) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_x[i] = tbl_x[i - 1];
            tbl_y[i] = tbl_y[i - 1];
          end
          tbl_x[pos] = it.coord_x;
          tbl_y[pos] = it.coord_y;
          tbl_count++;
        end
      end
      plc_pkg::KIND_EVAL: res.curve_value = curve_at(it.coord_x);
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", checked_count, what, got, want);
    error_count++;
  endtask

  // send one transaction and record its expected result; valid drops only
  // when a gap follows, so back to back transactions keep it high
  task automatic send_item(logic [1:0] kind, logic [31:0] x, logic [31:0] y);
    plc_pkg::in_item_t it;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.kind = kind;
    it.coord_x = x;
    it.coord_y = y;
    pending_results = {pending_results, predict_curve(it)};
    if (kind == plc_pkg::KIND_ADD && pending_results[$].status) full_drops++;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // result acceptance and stall generation
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      g = draining ? 0 : gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    plc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.curve_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.curve_value !== want.curve_value)
          report_mismatch("curve_value", out_data.curve_value, want.curve_value);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
      checked_count++;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
    endcase
  endfunction

  task automatic test_extremes();
    send_item(plc_pkg::KIND_EVAL, 32'h0001_0000, 32'h0);
    send_item(plc_pkg::KIND_ADD, 32'h8000_0000, 32'h8000_0000);
    send_item(plc_pkg::KIND_EVAL, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(plc_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(plc_pkg::KIND_EVAL, 32'h0, 32'h0);
    send_item(plc_pkg::KIND_EVAL, 32'h7FFF_FFFF, 32'h0);
    send_item(plc_pkg::KIND_EVAL, 32'h8000_0000, 32'h0);
    send_item(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(plc_pkg::KIND_CLEAR, 32'h0, 32'h0);
    // zero-width segment and extrapolation below the first point
    send_item(plc_pkg::KIND_ADD, 32'h0001_0000, 32'h0002_0000);
    send_item(plc_pkg::KIND_ADD, 32'h0001_0000, 32'h0005_0000);
    send_item(plc_pkg::KIND_ADD, 32'h0003_0000, 32'hFFFF_0000);
    send_item(plc_pkg::KIND_EVAL, 32'h0001_0000, 32'h0);
    send_item(plc_pkg::KIND_EVAL, 32'hFFFF_0000, 32'h0);
    send_item(plc_pkg::KIND_EVAL, 32'h0002_8000, 32'h0);
    send_item(plc_pkg::KIND_EVAL, 32'h0005_0000, 32'h0);
  endtask

  task automatic test_full_table();
    send_item(plc_pkg::KIND_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < plc_pkg::MAX_POINTS + 2; i++)
      send_item(plc_pkg::KIND_ADD, rand_coord(), rand_coord());
    send_item(plc_pkg::KIND_EVAL, rand_coord(), 32'h0);
  endtask

  // build tables then sweep queries, mostly ascending to exercise the cache
  task automatic test_random_curves();
    int n;
    logic [31:0] q;
    while (sent_count < 1800) begin
      send_item(plc_pkg::KIND_CLEAR, $urandom(), $urandom());
      n = $urandom_range(0, 99) < 80 ? $urandom_range(0, 6)
                                      : $urandom_range(7, plc_pkg::MAX_POINTS + 2);
      for (int i = 0; i < n; i++)
        send_item(plc_pkg::KIND_ADD, rand_coord(), rand_coord());
      q = rand_coord();
      for (int i = 0; i < $urandom_range(2, 12); i++) begin
        if ($urandom_range(0, 3) == 0) q = rand_coord();
        else q = q + ($urandom_range(0, 40) << 10);
        case ($urandom_range(0, 19))
          0: send_item(KIND_NONE, $urandom(), $urandom());
          1: send_item(plc_pkg::KIND_ADD, rand_coord(), rand_coord());
          default: send_item(plc_pkg::KIND_EVAL, q, $urandom());
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    cycle_count = 0;
    sent_count = 0;
    checked_count = 0;
    full_drops = 0;
    draining = 1'b0;
    tbl_count = 0;
    seg_cache = 0;
    last_query = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_table();
    test_random_curves();
    in_valid <= 1'b0;
    draining = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d transactions, checked %0d results, %0d adds to a full table",
             sent_count, checked_count, full_drops);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
